FILE: rtl/core/rmq_pkg.sv
// shared constants and types for the rotation matrix to quaternion core
// no dependencies; the other files that use it refer to it by scoped names
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ENTRY_W       = 16;
    localparam int Q32           = 32;
    localparam int LANES         = 4;
    localparam int PIVOT_W       = 2;
    localparam int TRACE_W       = 18;
    localparam int NUM_MAG_W     = 17;
    localparam int NORM_Q_W      = 34;
    localparam int OUT_MAX       = 32767;
    localparam int OUT_MIN_MAG   = 32768;

    localparam logic [PIVOT_W-1:0] PV_W = 2'd0;
    localparam logic [PIVOT_W-1:0] PV_X = 2'd1;
    localparam logic [PIVOT_W-1:0] PV_Y = 2'd2;
    localparam logic [PIVOT_W-1:0] PV_Z = 2'd3;

    typedef logic signed [ENTRY_W-1:0] entry_t;

endpackage

FILE: rtl/core/rmq_mat_if.sv
// matrix channel: valid, ready and the nine Q2.14 entries
// depends on rmq_pkg
interface rmq_mat_if;

    logic            valid;
    logic            ready;
    rmq_pkg::entry_t m00;
    rmq_pkg::entry_t m01;
    rmq_pkg::entry_t m02;
    rmq_pkg::entry_t m10;
    rmq_pkg::entry_t m11;
    rmq_pkg::entry_t m12;
    rmq_pkg::entry_t m20;
    rmq_pkg::entry_t m21;
    rmq_pkg::entry_t m22;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        input  ready
    );

    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        output ready
    );

endinterface

FILE: rtl/core/rmq_quat_if.sv
// quaternion channel: valid, ready, the four components and the pivot
// depends on rmq_pkg
interface rmq_quat_if;

    logic                          valid;
    logic                          ready;
    rmq_pkg::entry_t               qw;
    rmq_pkg::entry_t               qx;
    rmq_pkg::entry_t               qy;
    rmq_pkg::entry_t               qz;
    logic [rmq_pkg::PIVOT_W-1:0]   pivot;

    modport source (
        output valid, qw, qx, qy, qz, pivot,
        input  ready
    );

    modport sink (
        input  valid, qw, qx, qy, qz, pivot,
        output ready
    );

endinterface

FILE: rtl/core/rmq_front.sv
// front end: traces, pivot choice, off-diagonal numerators, first root operand
// depends on rmq_pkg and rmq_mat_if
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int S_W       = 37,
    parameter int RAD_W     = 70
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    rmq_mat_if.sink                                         mat,
    output logic                                            out_valid,
    output logic [RAD_W-1:0]                                rad,
    output logic [rmq_pkg::PIVOT_W-1:0]                     pivot,
    output logic [rmq_pkg::LANES-1:0]                       sign,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_MAG_W-1:0] mag
);

    localparam int SH = rmq_pkg::Q32 - FRAC_BITS;
    localparam int TW = rmq_pkg::TRACE_W;
    localparam int NW = rmq_pkg::NUM_MAG_W;
    localparam int L  = rmq_pkg::LANES;
    localparam logic signed [S_W:0] ONE_S = (S_W+1)'(1) << rmq_pkg::Q32;

    typedef logic signed [TW-1:0] trace_t;
    typedef logic signed [NW-1:0] num_t;

    logic   a_vld_reg;
    trace_t tr_reg [L];
    trace_t tr_next [L];
    num_t   d75_reg, s75_reg, d26_reg, s26_reg, d31_reg, s31_reg;

    logic                        b_vld_reg;
    logic [RAD_W-1:0]            rad_reg, rad_next;
    logic [rmq_pkg::PIVOT_W-1:0] piv_reg, piv_next;
    logic [L-1:0]                sign_reg, sign_next;
    logic [L-1:0][NW-1:0]        mag_reg, mag_next;

    num_t                n_lane [L];
    trace_t              tp;
    logic signed [S_W:0] s_full;
    logic [S_W-1:0]      s_pos;

    assign mat.ready = en;

    always_comb
    begin
        tr_next[0] =  TW'(mat.m00) + TW'(mat.m11) + TW'(mat.m22);
        tr_next[1] =  TW'(mat.m00) - TW'(mat.m11) - TW'(mat.m22);
        tr_next[2] = -TW'(mat.m00) + TW'(mat.m11) - TW'(mat.m22);
        tr_next[3] = -TW'(mat.m00) - TW'(mat.m11) + TW'(mat.m22);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= mat.valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_reg  <= tr_next;
            d75_reg <= NW'(mat.m21) - NW'(mat.m12);
            s75_reg <= NW'(mat.m21) + NW'(mat.m12);
            d26_reg <= NW'(mat.m02) - NW'(mat.m20);
            s26_reg <= NW'(mat.m02) + NW'(mat.m20);
            d31_reg <= NW'(mat.m10) - NW'(mat.m01);
            s31_reg <= NW'(mat.m10) + NW'(mat.m01);
            rad_reg  <= rad_next;
            piv_reg  <= piv_next;
            sign_reg <= sign_next;
            mag_reg  <= mag_next;
        end
    end

    // strict compares so that ties fall to the later component
    always_comb
    begin
        if (tr_reg[0] > tr_reg[1] && tr_reg[0] > tr_reg[2] && tr_reg[0] > tr_reg[3])
            piv_next = rmq_pkg::PV_W;
        else if (tr_reg[1] > tr_reg[2] && tr_reg[1] > tr_reg[3])
            piv_next = rmq_pkg::PV_X;
        else if (tr_reg[2] > tr_reg[3])
            piv_next = rmq_pkg::PV_Y;
        else
            piv_next = rmq_pkg::PV_Z;

        case (piv_next)
            rmq_pkg::PV_W:
            begin
                tp = tr_reg[0];
                n_lane[0] = '0;      n_lane[1] = d75_reg;
                n_lane[2] = d26_reg; n_lane[3] = d31_reg;
            end
            rmq_pkg::PV_X:
            begin
                tp = tr_reg[1];
                n_lane[0] = d75_reg; n_lane[1] = '0;
                n_lane[2] = s31_reg; n_lane[3] = s26_reg;
            end
            rmq_pkg::PV_Y:
            begin
                tp = tr_reg[2];
                n_lane[0] = d26_reg; n_lane[1] = s31_reg;
                n_lane[2] = '0;      n_lane[3] = s75_reg;
            end
            default:
            begin
                tp = tr_reg[3];
                n_lane[0] = d31_reg; n_lane[1] = s26_reg;
                n_lane[2] = s75_reg; n_lane[3] = '0;
            end
        endcase

        s_full   = ONE_S + ((S_W+1)'(tp) <<< SH);
        s_pos    = s_full[S_W] ? '0 : s_full[S_W-1:0];
        rad_next = RAD_W'({s_pos, {rmq_pkg::Q32{1'b0}}});

        for (int l = 0; l < L; l++)
        begin
            sign_next[l] = n_lane[l][NW-1];
            mag_next[l]  = n_lane[l][NW-1] ? NW'(-n_lane[l]) : NW'(n_lane[l]);
        end
    end

    assign out_valid = b_vld_reg;
    assign rad       = rad_reg;
    assign pivot     = piv_reg;
    assign sign      = sign_reg;
    assign mag       = mag_reg;

endmodule

FILE: rtl/core/rmq_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage, sideband carried along
// depends on nothing but the shared clock enable from the top
module rmq_sqrt_pipe #(
    parameter int RAD_W = 70,
    parameter int SB_W  = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     rad,
    input  logic [SB_W-1:0]      sb_in,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output logic [SB_W-1:0]      sb_out
);

    localparam int RT_W = RAD_W / 2;
    localparam int TW   = RAD_W + 1;

    logic [RT_W-1:0]  vld_reg;
    logic [RAD_W-1:0] rem_reg  [RT_W];
    logic [RAD_W-1:0] rem_next [RT_W];
    logic [RT_W-1:0]  root_reg  [RT_W];
    logic [RT_W-1:0]  root_next [RT_W];
    logic [SB_W-1:0]  sb_reg [RT_W];

    // stage k settles root bit RT_W-1-k against rem = radicand - root^2
    always_comb
    begin
        logic [RAD_W-1:0] c_rem;
        logic [RT_W-1:0]  c_root;
        logic [TW-1:0]    trial;
        int               b;
        for (int k = 0; k < RT_W; k++)
        begin
            if (k == 0)
            begin
                c_rem  = rad;
                c_root = '0;
            end
            else
            begin
                c_rem  = rem_reg[k-1];
                c_root = root_reg[k-1];
            end
            b            = RT_W - 1 - k;
            trial        = (TW'(c_root) << (b + 1)) | (TW'(1) << (2 * b));
            rem_next[k]  = c_rem;
            root_next[k] = c_root;
            if (TW'(c_rem) >= trial)
            begin
                rem_next[k]     = c_rem - RAD_W'(trial);
                root_next[k][b] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[RT_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            sb_reg[0] <= sb_in;
            for (int k = 1; k < RT_W; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    assign out_valid = vld_reg[RT_W-1];
    assign root      = root_reg[RT_W-1];
    assign sb_out    = sb_reg[RT_W-1];

endmodule

FILE: rtl/core/rmq_div_pipe.sv
// pipelined restoring divider over several lanes sharing one divisor,
// one quotient bit per stage; depends on nothing but the shared clock enable
module rmq_div_pipe #(
    parameter int LANES = 4,
    parameter int NUM_W = 16,
    parameter int DEN_W = 16,
    parameter int Q_W   = 8,
    parameter int SB_W  = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [SB_W-1:0]             sb_in,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   quo,
    output logic [SB_W-1:0]             sb_out
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W-1:0]              vld_reg;
    logic [LANES-1:0][NUM_W-1:0] rem_reg  [Q_W];
    logic [LANES-1:0][NUM_W-1:0] rem_next [Q_W];
    logic [LANES-1:0][Q_W-1:0]   quo_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   quo_next [Q_W];
    logic [DEN_W-1:0]            den_reg [Q_W];
    logic [SB_W-1:0]             sb_reg  [Q_W];

    // numerator is known to stay below den * 2^Q_W, so no quotient bit is lost
    always_comb
    begin
        logic [LANES-1:0][NUM_W-1:0] c_rem;
        logic [LANES-1:0][Q_W-1:0]   c_quo;
        logic [DEN_W-1:0]            c_den;
        logic [CW-1:0]               sub;
        int                          b;
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                c_rem = num;
                c_quo = '0;
                c_den = den;
            end
            else
            begin
                c_rem = rem_reg[k-1];
                c_quo = quo_reg[k-1];
                c_den = den_reg[k-1];
            end
            b           = Q_W - 1 - k;
            sub         = CW'(c_den) << b;
            rem_next[k] = c_rem;
            quo_next[k] = c_quo;
            for (int i = 0; i < LANES; i++)
            begin
                if (CW'(c_rem[i]) >= sub)
                begin
                    rem_next[k][i]    = c_rem[i] - NUM_W'(sub);
                    quo_next[k][i][b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Q_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            den_reg[0] <= den;
            sb_reg[0]  <= sb_in;
            for (int k = 1; k < Q_W; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                sb_reg[k]  <= sb_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign sb_out    = sb_reg[Q_W-1];

endmodule

FILE: rtl/core/rmq_sumsq.sv
// sum of squares of the four component magnitudes in Q.32, three stages:
// split partial products, recombine and scale, add; depends on rmq_pkg
module rmq_sumsq #(
    parameter int QM_W = 35,
    parameter int SB_W = 1,
    localparam int SUM_W = 2 * QM_W - 30
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [rmq_pkg::LANES-1:0][QM_W-1:0]   a,
    input  logic [SB_W-1:0]                       sb_in,
    output logic                                  out_valid,
    output logic [SUM_W-1:0]                      sum,
    output logic [SB_W-1:0]                       sb_out
);

    localparam int L    = rmq_pkg::LANES;
    localparam int H    = (QM_W + 1) / 2;
    localparam int HI_W = QM_W - H;
    localparam int SQ_W = 2 * QM_W - rmq_pkg::Q32;
    localparam int FW   = 2 * QM_W + 2;

    logic [2:0]          vld_reg;
    logic [2*HI_W-1:0]   hh_reg [L];
    logic [HI_W+H-1:0]   hl_reg [L];
    logic [2*H-1:0]      ll_reg [L];
    logic [SQ_W-1:0]     sq_reg  [L];
    logic [SQ_W-1:0]     sq_next [L];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SB_W-1:0]     sb_reg [3];

    always_comb
    begin
        logic [FW-1:0] full;
        sum_next = '0;
        for (int l = 0; l < L; l++)
        begin
            full = (FW'(hh_reg[l]) << (2 * H)) + (FW'(hl_reg[l]) << (H + 1))
                 + FW'(ll_reg[l]);
            sq_next[l] = full[2*QM_W-1:rmq_pkg::Q32];
            sum_next   = sum_next + SUM_W'(sq_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < L; l++)
            begin
                hh_reg[l] <= (2*HI_W)'(a[l][QM_W-1:H]) * (2*HI_W)'(a[l][QM_W-1:H]);
                hl_reg[l] <= (HI_W+H)'(a[l][QM_W-1:H]) * (HI_W+H)'(a[l][H-1:0]);
                ll_reg[l] <= (2*H)'(a[l][H-1:0]) * (2*H)'(a[l][H-1:0]);
            end
            sq_reg    <= sq_next;
            sum_reg   <= sum_next;
            sb_reg[0] <= sb_in;
            sb_reg[1] <= sb_reg[0];
            sb_reg[2] <= sb_reg[1];
        end
    end

    assign out_valid = vld_reg[2];
    assign sum       = sum_reg;
    assign sb_out    = sb_reg[2];

endmodule

FILE: rtl/core/rotation_matrix_to_quaternion_core.sv
// top level: rotation matrix to unit quaternion by the largest-trace method
// depends on rmq_pkg, rmq_mat_if, rmq_quat_if, rmq_front, rmq_sqrt_pipe,
// rmq_div_pipe and rmq_sumsq
//
//  channel  modport  payload                        transaction
//  mat      sink     m00 .. m22, signed Q2.14       one matrix
//  quat     source   qw qx qy qz Q2.14, pivot       one quaternion
//
// one matrix enters per cycle unless quat stalls; a matrix passes the front end,
// the pivot root, the component divider, the sum of squares, the length root, the
// normalizing divider and the output register, roots and dividers one bit per stage
// reset clears only the valid bits of every stage
// when quat holds a transaction that is not taken, the whole pipeline freezes
// and mat.ready drops in the same cycle
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rmq_mat_if.sink     mat,
    rmq_quat_if.source  quat
);

    localparam int L      = rmq_pkg::LANES;
    localparam int PW     = rmq_pkg::PIVOT_W;
    localparam int NW     = rmq_pkg::NUM_MAG_W;
    localparam int Q32    = rmq_pkg::Q32;
    localparam int QN_W   = rmq_pkg::NORM_Q_W;
    localparam int SH     = Q32 - FRAC_BITS;
    localparam int S_W    = ((SH + NW > Q32) ? SH + NW : Q32) + 1;
    localparam int RAD1_W = 2 * ((S_W + Q32 + 1) / 2);
    localparam int RT1_W  = RAD1_W / 2;
    localparam int C_W    = RT1_W - 1;
    localparam int DEN1_W = RT1_W + 1;
    localparam int NUM1_W = NW + SH + Q32;
    localparam int Q1_W   = SH + 16;
    localparam int QM_W   = (Q1_W > C_W) ? Q1_W : C_W;
    localparam int SUM_W  = 2 * QM_W - 30;
    localparam int RAD2_W = 2 * ((SUM_W + Q32 + 1) / 2);
    localparam int RT2_W  = RAD2_W / 2;
    localparam int NUM2_W = QM_W + Q32;
    localparam int SB1_W  = PW + L + L * NW;
    localparam int SB2_W  = PW + L + C_W;
    localparam int SB3_W  = PW + L + L * QM_W;
    localparam int SB4_W  = PW + L;

    logic adv;

    // front end
    logic                  f_vld;
    logic [RAD1_W-1:0]     f_rad;
    logic [PW-1:0]         f_piv;
    logic [L-1:0]          f_sign;
    logic [L-1:0][NW-1:0]  f_mag;

    // pivot root
    logic                  s1_vld;
    logic [RT1_W-1:0]      s1_root;
    logic [SB1_W-1:0]      s1_sb;
    logic [L-1:0][NW-1:0]  s1_mag;
    logic [C_W-1:0]        s1_c;
    logic [L-1:0][NUM1_W-1:0] num1;

    // off-diagonal quotients
    logic                  d1_vld;
    logic [L-1:0][Q1_W-1:0] d1_quo;
    logic [SB2_W-1:0]      d1_sb;
    logic [PW-1:0]         d1_piv;
    logic [C_W-1:0]        d1_c;
    logic [L-1:0][QM_W-1:0] d1_a;

    // length
    logic                  ss_vld;
    logic [SUM_W-1:0]      ss_sum;
    logic [SB3_W-1:0]      ss_sb;
    logic                  s2_vld;
    logic [RT2_W-1:0]      s2_root;
    logic [SB3_W-1:0]      s2_sb;
    logic [L-1:0][QM_W-1:0] s2_a;
    logic [L-1:0][NUM2_W-1:0] num2;

    // normalized
    logic                  d2_vld;
    logic [L-1:0][QN_W-1:0] d2_quo;
    logic [SB4_W-1:0]      d2_sb;
    logic [PW-1:0]         d2_piv;
    logic [L-1:0]          d2_sign;

    logic                    out_vld_reg;
    rmq_pkg::entry_t         q_reg  [L];
    rmq_pkg::entry_t         q_next [L];
    logic [PW-1:0]           piv_reg;

    assign adv = !out_vld_reg || quat.ready;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .S_W       (S_W),
        .RAD_W     (RAD1_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .mat       (mat),
        .out_valid (f_vld),
        .rad       (f_rad),
        .pivot     (f_piv),
        .sign      (f_sign),
        .mag       (f_mag)
    );

    rmq_sqrt_pipe #(
        .RAD_W (RAD1_W),
        .SB_W  (SB1_W)
    ) u_sqrt_pivot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f_vld),
        .rad       (f_rad),
        .sb_in     ({f_piv, f_sign, f_mag}),
        .out_valid (s1_vld),
        .root      (s1_root),
        .sb_out    (s1_sb)
    );

    assign s1_mag = s1_sb[L*NW-1:0];
    assign s1_c   = s1_root[RT1_W-1:1];

    always_comb
    begin
        for (int l = 0; l < L; l++)
            num1[l] = {s1_mag[l], {(SH + Q32){1'b0}}};
    end

    rmq_div_pipe #(
        .LANES (L),
        .NUM_W (NUM1_W),
        .DEN_W (DEN1_W),
        .Q_W   (Q1_W),
        .SB_W  (SB2_W)
    ) u_div_comp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_vld),
        .num       (num1),
        .den       ({s1_c, 2'b00}),
        .sb_in     ({s1_sb[SB1_W-1 -: PW + L], s1_c}),
        .out_valid (d1_vld),
        .quo       (d1_quo),
        .sb_out    (d1_sb)
    );

    assign d1_piv = d1_sb[SB2_W-1 -: PW];
    assign d1_c   = d1_sb[C_W-1:0];

    // the pivot lane takes the half root itself
    always_comb
    begin
        for (int l = 0; l < L; l++)
            d1_a[l] = (d1_piv == PW'(l)) ? QM_W'(d1_c) : QM_W'(d1_quo[l]);
    end

    rmq_sumsq #(
        .QM_W (QM_W),
        .SB_W (SB3_W)
    ) u_sumsq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d1_vld),
        .a         (d1_a),
        .sb_in     ({d1_sb[SB2_W-1 -: PW + L], d1_a}),
        .out_valid (ss_vld),
        .sum       (ss_sum),
        .sb_out    (ss_sb)
    );

    rmq_sqrt_pipe #(
        .RAD_W (RAD2_W),
        .SB_W  (SB3_W)
    ) u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ss_vld),
        .rad       (RAD2_W'({ss_sum, {Q32{1'b0}}})),
        .sb_in     (ss_sb),
        .out_valid (s2_vld),
        .root      (s2_root),
        .sb_out    (s2_sb)
    );

    assign s2_a = s2_sb[L*QM_W-1:0];

    always_comb
    begin
        for (int l = 0; l < L; l++)
            num2[l] = {s2_a[l], {Q32{1'b0}}};
    end

    rmq_div_pipe #(
        .LANES (L),
        .NUM_W (NUM2_W),
        .DEN_W (RT2_W),
        .Q_W   (QN_W),
        .SB_W  (SB4_W)
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_vld),
        .num       (num2),
        .den       (s2_root),
        .sb_in     (s2_sb[SB3_W-1 -: SB4_W]),
        .out_valid (d2_vld),
        .quo       (d2_quo),
        .sb_out    (d2_sb)
    );

    assign d2_piv  = d2_sb[SB4_W-1 -: PW];
    assign d2_sign = d2_sb[L-1:0];

    // back to FRAC_BITS with saturation, sign applied to the magnitude
    always_comb
    begin
        logic [QN_W-1:0] m;
        for (int l = 0; l < L; l++)
        begin
            m = d2_quo[l] >> SH;
            if (d2_sign[l])
                q_next[l] = (m > QN_W'(rmq_pkg::OUT_MIN_MAG))
                          ? rmq_pkg::entry_t'(-rmq_pkg::OUT_MIN_MAG)
                          : rmq_pkg::entry_t'(-m[rmq_pkg::ENTRY_W-1:0]);
            else
                q_next[l] = (m > QN_W'(rmq_pkg::OUT_MAX))
                          ? rmq_pkg::entry_t'(rmq_pkg::OUT_MAX)
                          : rmq_pkg::entry_t'(m[rmq_pkg::ENTRY_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg   <= q_next;
            piv_reg <= d2_piv;
        end
    end

    assign quat.valid = out_vld_reg;
    assign quat.qw    = q_reg[0];
    assign quat.qx    = q_reg[1];
    assign quat.qy    = q_reg[2];
    assign quat.qz    = q_reg[3];
    assign quat.pivot = piv_reg;

endmodule

FILE: tb/tb.sv
// self-checking bench for rotation_matrix_to_quaternion_core: matrices in, quaternions out
// depends on rmq_pkg, rmq_mat_if, rmq_quat_if and the core; expected values come
// from a fixed-point predictor kept in this file
module tb;

    localparam int N_ITEMS   = 1650;
    localparam int QUIET_N   = 150;
    localparam int LATENCY   = 143;
    localparam int CYC_LIMIT = 200000;
    localparam int UP        = 32 - rmq_pkg::FRAC_BITS_DEF;

    typedef struct {
        rmq_pkg::entry_t m [9];
    } matrix_t;

    typedef struct {
        rmq_pkg::entry_t                w, x, y, z;
        logic [rmq_pkg::PIVOT_W-1:0]    pv;
    } quat_t;

    logic clk;
    logic rst_n;

    rmq_mat_if  mat_ch ();
    rmq_quat_if quat_ch ();

    rotation_matrix_to_quaternion_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat_ch),
        .quat  (quat_ch)
    );

    matrix_t pending_mats [$];
    quat_t   expected_quats [$];
    int      n_sent;
    int      n_checked;
    int      n_errors;
    int      pivot_hits [4];
    int      cycles;
    int      in_gap;
    int      out_gap;
    int      hold_left;
    bit      hold_done;
    bit      stim_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor of the square root of a wide unsigned value
    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r[63:0];
    endfunction

    function automatic logic [63:0] magnitude(longint signed n);
        return n < 0 ? 64'd0 - 64'(n) : 64'(n);
    endfunction

    // q32 quotient, truncated toward zero
    function automatic longint signed q32_div(longint signed n, logic [63:0] d);
        logic [127:0] q;
        if (d == 0)
            return 0;
        q = ({64'd0, magnitude(n)} << 32) / {64'd0, d};
        return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic rmq_pkg::entry_t to_q2_14(longint signed v);
        logic [63:0] m;
        m = magnitude(v) >> UP;
        if (v < 0)
            return (m > 64'd32768) ? -16'sd32768 : rmq_pkg::entry_t'(-longint'(m));
        return (m > 64'd32767) ? 16'sd32767 : rmq_pkg::entry_t'(m);
    endfunction

    function automatic quat_t predict_quat(matrix_t mx);
        longint signed e [9];
        longint signed tr [4];
        longint signed num [4];
        longint signed q [4];
        longint signed s;
        logic [63:0]   c;
        logic [63:0]   den;
        logic [63:0]   sum;
        logic [63:0]   len;
        logic [127:0]  sq;
        int            p;
        quat_t         r;
        for (int i = 0; i < 9; i++)
            e[i] = longint'(mx.m[i]) * (longint'(1) << UP);
        tr[0] = e[0] + e[4] + e[8];
        tr[1] = e[0] - e[4] - e[8];
        tr[2] = -e[0] + e[4] - e[8];
        tr[3] = -e[0] - e[4] + e[8];
        if (tr[0] > tr[1] && tr[0] > tr[2] && tr[0] > tr[3])
            p = 0;
        else if (tr[1] > tr[2] && tr[1] > tr[3])
            p = 1;
        else if (tr[2] > tr[3])
            p = 2;
        else
            p = 3;
        case (p)
            0:
            begin
                num[1] = e[7] - e[5]; num[2] = e[2] - e[6]; num[3] = e[3] - e[1];
            end
            1:
            begin
                num[0] = e[7] - e[5]; num[2] = e[3] + e[1]; num[3] = e[2] + e[6];
            end
            2:
            begin
                num[0] = e[2] - e[6]; num[1] = e[3] + e[1]; num[3] = e[7] + e[5];
            end
            default:
            begin
                num[0] = e[3] - e[1]; num[1] = e[2] + e[6]; num[2] = e[7] + e[5];
            end
        endcase
        num[p] = 0;
        s = (longint'(1) << 32) + tr[p];
        if (s < 0)
            s = 0;
        c   = isqrt({64'd0, 64'(s)} << 32) >> 1;
        den = c << 2;
        for (int i = 0; i < 4; i++)
            q[i] = (i == p) ? longint'(c) : q32_div(num[i], den);
        sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            sq  = {64'd0, magnitude(q[i])} * {64'd0, magnitude(q[i])};
            sum = sum + sq[95:32];
        end
        len  = isqrt({64'd0, sum} << 32);
        r.w  = to_q2_14(q32_div(q[0], len));
        r.x  = to_q2_14(q32_div(q[1], len));
        r.y  = to_q2_14(q32_div(q[2], len));
        r.z  = to_q2_14(q32_div(q[3], len));
        r.pv = p[rmq_pkg::PIVOT_W-1:0];
        return r;
    endfunction

    function automatic rmq_pkg::entry_t from_real(real v);
        real k;
        k = v * 16384.0;
        if (k > 32767.0)
            return 16'sd32767;
        if (k < -32768.0)
            return -16'sd32768;
        return rmq_pkg::entry_t'($rtoi(k));
    endfunction

    function automatic real rand_unit();
        return ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    endfunction

    // proper rotation from a random quaternion, optionally with up to noise lsb of noise per entry
    function automatic matrix_t rand_rotation(int noise);
        real     a, b, c, d, n;
        matrix_t mx;
        a = rand_unit(); b = rand_unit(); c = rand_unit(); d = rand_unit();
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0e-3)
        begin
            a = 1.0; n = 1.0;
        end
        a = a / n; b = b / n; c = c / n; d = d / n;
        mx.m[0] = from_real(1.0 - 2.0 * (c * c + d * d));
        mx.m[1] = from_real(2.0 * (b * c - a * d));
        mx.m[2] = from_real(2.0 * (b * d + a * c));
        mx.m[3] = from_real(2.0 * (b * c + a * d));
        mx.m[4] = from_real(1.0 - 2.0 * (b * b + d * d));
        mx.m[5] = from_real(2.0 * (c * d - a * b));
        mx.m[6] = from_real(2.0 * (b * d - a * c));
        mx.m[7] = from_real(2.0 * (c * d + a * b));
        mx.m[8] = from_real(1.0 - 2.0 * (b * b + c * c));
        if (noise > 0)
            for (int i = 0; i < 9; i++)
                mx.m[i] = mx.m[i]
                        + rmq_pkg::entry_t'($urandom_range(0, 2 * noise) - noise);
        return mx;
    endfunction

    function automatic matrix_t diag_mat(rmq_pkg::entry_t a, rmq_pkg::entry_t b,
                                         rmq_pkg::entry_t c, rmq_pkg::entry_t off);
        matrix_t mx;
        for (int i = 0; i < 9; i++)
            mx.m[i] = off;
        mx.m[0] = a;
        mx.m[4] = b;
        mx.m[8] = c;
        return mx;
    endfunction

    initial
    begin
        matrix_t mx;
        int      pick;
        mat_ch.valid  = 1'b0;
        mat_ch.m00    = '0; mat_ch.m01 = '0; mat_ch.m02 = '0;
        mat_ch.m10    = '0; mat_ch.m11 = '0; mat_ch.m12 = '0;
        mat_ch.m20    = '0; mat_ch.m21 = '0; mat_ch.m22 = '0;
        quat_ch.ready = 1'b0;
        rst_n         = 1'b0;

        // identity and the half turns pick each pivot
        pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
        pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));
        pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));
        pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));
        // ties among traces fall to the later component
        pending_mats.push_back(diag_mat(0, 0, 0, 0));
        pending_mats.push_back(diag_mat(16384, 16384, 0, 0));
        pending_mats.push_back(diag_mat(-16384, 0, 0, 0));
        pending_mats.push_back(diag_mat(0, -16384, -16384, 1000));
        // field extremes, not rotations, with saturation on the way out
        pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
        pending_mats.push_back(diag_mat(-32768, -32768, -32768, -32768));
        pending_mats.push_back(diag_mat(32767, -32768, -32768, 32767));
        pending_mats.push_back(diag_mat(-32768, 32767, -32768, -32768));
        pending_mats.push_back(diag_mat(-32768, -32768, 32767, 32767));
        pending_mats.push_back(diag_mat(32767, 32767, 32767, -32768));
        for (int i = 0; i < 9; i++)
        begin
            mx = diag_mat(0, 0, 0, 0);
            mx.m[i] = (i % 2) ? 16'sd32767 : -16'sd32768;
            pending_mats.push_back(mx);
        end

        while (pending_mats.size() < N_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                mx = rand_rotation(0);
            else if (pick < 80)
                mx = rand_rotation($urandom_range(1, 200));
            else
                for (int i = 0; i < 9; i++)
                    mx.m[i] = rmq_pkg::entry_t'($urandom());
            pending_mats.push_back(mx);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_mats.size() == 0 && n_sent == N_ITEMS);
        wait (expected_quats.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        stim_done = 1'b1;
        $display("%0d matrices sent, %0d quaternions checked, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("pivot w %0d, x %0d, y %0d, z %0d; one long output stall included",
                 pivot_hits[0], pivot_hits[1], pivot_hits[2], pivot_hits[3]);
        if (n_errors == 0 && expected_quats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // matrix driver
    always @(posedge clk)
    begin
        matrix_t mx;
        matrix_t cur;
        if (rst_n)
        begin
            if (mat_ch.valid && mat_ch.ready)
            begin
                cur.m = '{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
                          mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22};
                expected_quats.push_back(predict_quat(cur));
                n_sent++;
            end
            if (!mat_ch.valid || mat_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    mat_ch.valid <= 1'b0;
                end
                else if (pending_mats.size() > 0)
                begin
                    mx = pending_mats.pop_front();
                    mat_ch.m00 <= mx.m[0]; mat_ch.m01 <= mx.m[1]; mat_ch.m02 <= mx.m[2];
                    mat_ch.m10 <= mx.m[3]; mat_ch.m11 <= mx.m[4]; mat_ch.m12 <= mx.m[5];
                    mat_ch.m20 <= mx.m[6]; mat_ch.m21 <= mx.m[7]; mat_ch.m22 <= mx.m[8];
                    mat_ch.valid <= 1'b1;
                    if (pending_mats.size() > QUIET_N && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 3);
                end
                else
                    mat_ch.valid <= 1'b0;
            end
        end
    end

    // quaternion receiver back-pressure, with one long hold-off to fill the pipe
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && n_sent >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                quat_ch.ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                quat_ch.ready <= 1'b0;
            end
            else
            begin
                quat_ch.ready <= 1'b1;
                if (pending_mats.size() > QUIET_N && $urandom_range(0, 5) == 0)
                    out_gap = $urandom_range(1, 3);
            end
        end
    end

    // quaternion checker
    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && quat_ch.valid && quat_ch.ready)
        begin
            if (expected_quats.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected quaternion w %0d x %0d y %0d z %0d pivot %0d",
                         $time, quat_ch.qw, quat_ch.qx, quat_ch.qy, quat_ch.qz,
                         quat_ch.pivot);
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                n_checked++;
                pivot_hits[exp_q.pv]++;
                if (quat_ch.qw !== exp_q.w || quat_ch.qx !== exp_q.x ||
                    quat_ch.qy !== exp_q.y || quat_ch.qz !== exp_q.z ||
                    quat_ch.pivot !== exp_q.pv)
                begin
                    n_errors++;
                    $display("%0t: expected w %0d x %0d y %0d z %0d pv %0d, got %s",
                             $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.pv,
                             $sformatf("w %0d x %0d y %0d z %0d pv %0d",
                                       quat_ch.qw, quat_ch.qx, quat_ch.qy,
                                       quat_ch.qz, quat_ch.pivot));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT && !stim_done)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_mat_if.sv
rtl/core/rmq_quat_if.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt_pipe.sv
rtl/core/rmq_div_pipe.sv
rtl/core/rmq_sumsq.sv
rtl/core/rotation_matrix_to_quaternion_core.sv
tb/tb.sv
